// ===== rtl/core/oate_pkg.sv =====
// Package for the ordered array table engine: command and status codes,
// sequencer state type and size constants. No dependencies.
`default_nettype none
package oate_pkg;
    localparam int DEPTH_DEF = 256;
    localparam int VAL_W = 32;
    localparam int FUNC_W = 3;
    localparam int POS_W = 9;
    localparam int MIDX_W = 8;
    localparam int CNT_W = 9;

    typedef enum logic [2:0] {
        FN_INSERT = 3'd0,
        FN_DEL_IDX = 3'd1,
        FN_DEL_VAL = 3'd2,
        FN_SEARCH = 3'd3,
        FN_SORT = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_FULL = 2'd1,
        ST_RANGE = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SORT_RD,
        S_SORT_CMP,
        S_SORT_STEP,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/oate_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module oate_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/ordered_array_table_engine_core.sv =====
// Top level of the ordered array table engine: command sequencer over one
// table RAM. Depends on oate_pkg and oate_ram.
//
//  channel | dir | fields (tdata low bit up)
//  s_      | in  | func[2:0], position[11:3], value[43:12], pad to 48
//  m_      | out | status[1:0], found[2], match_index[10:3], entry_count[19:11]
//
// One RAM port with registered read. Insert/delete at index: a read and a
// write per shifted entry. Search: a read and a compare per entry scanned;
// delete by value: the scan, then the delete-at-index shift. Sort is an
// insertion sort. Full, range and unused codes go straight to the done state.
// Reset clears the count.
// A result waits in the output register; the next beat is taken once it goes.
`default_nettype none
module ordered_array_table_engine_core #(
    parameter int DEPTH = oate_pkg::DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // func, position, value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // status, found, match_index, entry_count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = oate_pkg::POS_W;
    localparam int EW = (CW > PW) ? CW : PW;

    oate_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0] func_reg;
    logic [PW-1:0] pos_reg;
    logic [31:0] val_reg;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [31:0] key_reg, key_next;
    logic hold_reg, hold_next;
    logic [1:0] stat_reg, stat_next;
    logic found_reg, found_next;
    logic [7:0] midx_reg, midx_next;
    logic out_v_reg;

    logic we;
    logic [AW-1:0] addr;
    logic [31:0] wdata, rdata;
    logic take;

    oate_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign s_tready = (state_reg == oate_pkg::S_IDLE) && !out_v_reg;
    assign take = s_tvalid && s_tready;
    assign m_tvalid = out_v_reg;
    assign m_tdata = {4'd0, 9'(cnt_reg), midx_reg, found_reg, stat_reg};

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        i_next = i_reg;
        j_next = j_reg;
        key_next = key_reg;
        hold_next = hold_reg;
        stat_next = stat_reg;
        found_next = found_reg;
        midx_next = midx_reg;
        unique case (state_reg)
            oate_pkg::S_IDLE: begin
                if (take) begin
                    stat_next = oate_pkg::ST_OK;
                    found_next = 1'b0;
                    midx_next = '0;
                    i_next = '0;
                    unique case (s_tdata[2:0])
                        oate_pkg::FN_INSERT: begin
                            if ({1'b0, cnt_reg} >= (CW+1)'(DEPTH)) begin
                                stat_next = oate_pkg::ST_FULL;
                                state_next = oate_pkg::S_DONE;
                            end else if (EW'(s_tdata[11:3]) > EW'(cnt_reg)) begin
                                stat_next = oate_pkg::ST_RANGE;
                                state_next = oate_pkg::S_DONE;
                            end else begin
                                i_next = cnt_reg;
                                state_next = oate_pkg::S_INS_RD;
                            end
                        end
                        oate_pkg::FN_DEL_IDX: begin
                            if (EW'(s_tdata[11:3]) >= EW'(cnt_reg)) begin
                                stat_next = oate_pkg::ST_RANGE;
                                state_next = oate_pkg::S_DONE;
                            end else begin
                                i_next = CW'(s_tdata[11:3]);
                                state_next = oate_pkg::S_DEL_RD;
                            end
                        end
                        oate_pkg::FN_DEL_VAL, oate_pkg::FN_SEARCH: begin
                            state_next = oate_pkg::S_SRCH_RD;
                        end
                        oate_pkg::FN_SORT: begin
                            i_next = CW'(1);
                            state_next = oate_pkg::S_SORT_RD;
                        end
                        default: state_next = oate_pkg::S_DONE;
                    endcase
                end
            end
            oate_pkg::S_INS_RD: begin
                if (EW'(i_reg) == EW'(pos_reg)) begin
                    cnt_next = cnt_reg + 1'b1;
                    state_next = oate_pkg::S_DONE;
                end else begin
                    state_next = oate_pkg::S_INS_WR;
                end
            end
            oate_pkg::S_INS_WR: begin
                i_next = i_reg - 1'b1;
                state_next = oate_pkg::S_INS_RD;
            end
            oate_pkg::S_DEL_RD: begin
                if (i_reg + 1'b1 >= cnt_reg) begin
                    cnt_next = cnt_reg - 1'b1;
                    state_next = oate_pkg::S_DONE;
                end else begin
                    state_next = oate_pkg::S_DEL_WR;
                end
            end
            oate_pkg::S_DEL_WR: begin
                i_next = i_reg + 1'b1;
                state_next = oate_pkg::S_DEL_RD;
            end
            oate_pkg::S_SRCH_RD: begin
                if (i_reg >= cnt_reg) begin
                    stat_next = oate_pkg::ST_MISS;
                    state_next = oate_pkg::S_DONE;
                end else begin
                    state_next = oate_pkg::S_SRCH_CMP;
                end
            end
            oate_pkg::S_SRCH_CMP: begin
                if (rdata == val_reg) begin
                    found_next = 1'b1;
                    midx_next = 8'(i_reg);
                    if (func_reg == oate_pkg::FN_DEL_VAL) begin
                        state_next = oate_pkg::S_DEL_RD;
                    end else begin
                        state_next = oate_pkg::S_DONE;
                    end
                end else begin
                    i_next = i_reg + 1'b1;
                    state_next = oate_pkg::S_SRCH_RD;
                end
            end
            oate_pkg::S_SORT_RD: begin
                // read key at i; j starts at i
                if (i_reg >= cnt_reg) begin
                    state_next = oate_pkg::S_DONE;
                end else begin
                    j_next = i_reg;
                    state_next = oate_pkg::S_SORT_CMP;
                end
            end
            oate_pkg::S_SORT_CMP: begin
                // first entry here: rdata is key; later: rdata is entries[j-1]
                if (j_reg == i_reg && !hold_reg) begin
                    key_next = rdata;
                    hold_next = 1'b1;
                end else if (j_reg != 0 && $signed(key_reg) < $signed(rdata)) begin
                    j_next = j_reg - 1'b1;
                    state_next = oate_pkg::S_SORT_STEP;
                end else begin
                    hold_next = 1'b0;
                    i_next = i_reg + 1'b1;
                    state_next = oate_pkg::S_SORT_RD;
                end
            end
            oate_pkg::S_SORT_STEP: begin
                state_next = oate_pkg::S_SORT_CMP;
            end
            oate_pkg::S_DONE: begin
                state_next = oate_pkg::S_IDLE;
            end
            default: state_next = oate_pkg::S_IDLE;
        endcase
    end

    // RAM access
    always_comb begin
        we = 1'b0;
        addr = '0;
        wdata = val_reg;
        unique case (state_reg)
            oate_pkg::S_INS_RD: begin
                if (EW'(i_reg) == EW'(pos_reg)) begin
                    we = 1'b1;
                    addr = i_reg[AW-1:0];
                    wdata = val_reg;
                end else begin
                    addr = AW'(i_reg - 1'b1);
                end
            end
            oate_pkg::S_INS_WR: begin
                we = 1'b1;
                addr = i_reg[AW-1:0];
                wdata = rdata;
            end
            oate_pkg::S_DEL_RD: addr = AW'(i_reg + 1'b1);
            oate_pkg::S_DEL_WR: begin
                we = 1'b1;
                addr = i_reg[AW-1:0];
                wdata = rdata;
            end
            oate_pkg::S_SRCH_RD: addr = i_reg[AW-1:0];
            oate_pkg::S_SORT_RD: addr = i_reg[AW-1:0];
            oate_pkg::S_SORT_CMP: begin
                if (j_reg == i_reg && !hold_reg) begin
                    addr = AW'(j_reg - 1'b1);
                end else if (j_reg != 0 && $signed(key_reg) < $signed(rdata)) begin
                    we = 1'b1;
                    addr = j_reg[AW-1:0];
                    wdata = rdata;
                end else begin
                    we = 1'b1;
                    addr = j_reg[AW-1:0];
                    wdata = key_reg;
                end
            end
            oate_pkg::S_SORT_STEP: addr = AW'(j_reg - 1'b1);
            default: ;
        endcase
    end

    // sort compare first time through needs entries[j-1] read; in SORT_CMP
    // with hold set and j==i it compares rdata = entries[i-1]
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= oate_pkg::S_IDLE;
            cnt_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (state_reg == oate_pkg::S_DONE) begin
                out_v_reg <= 1'b1;
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            func_reg <= s_tdata[2:0];
            pos_reg <= s_tdata[11:3];
            val_reg <= s_tdata[43:12];
            hold_reg <= 1'b0;
        end else begin
            hold_reg <= hold_next;
        end
        i_reg <= i_next;
        j_reg <= j_next;
        key_reg <= key_next;
        stat_reg <= stat_next;
        found_reg <= found_next;
        midx_reg <= midx_next;
    end
endmodule
`default_nettype wire

// ===== bench/ordered_array_table_engine_core_chk.sv =====
// Result checker for the ordered array table engine: watches both channels,
// keeps its own table and count, and compares every result beat.
// Depends on oate_pkg.
`timescale 1ns / 100ps
module ordered_array_table_engine_core_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          err_count,
    output int          pending,
    output int          cmd_seen,
    output int          hit_seen
);
    typedef struct packed {
        logic [8:0]        entry_count;
        logic [7:0]        match_index;
        logic              found;
        oate_pkg::status_t status;
    } table_reply_t;

    logic signed [31:0] tbl[256];
    int                 tbl_count;
    table_reply_t       reply_q[$];

    function automatic int find_value(logic signed [31:0] v);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl[i] == v) return i;
        end
        return -1;
    endfunction

    function automatic table_reply_t apply_command(logic [47:0] beat);
        logic [2:0]         fn;
        int                 pos;
        logic signed [31:0] v;
        table_reply_t       r;
        int                 hit;
        logic signed [31:0] key;
        int                 j;
        fn = beat[2:0];
        pos = beat[11:3];
        v = beat[43:12];
        r = '0;
        r.status = oate_pkg::ST_OK;
        case (fn)
            oate_pkg::FN_INSERT: begin
                if (tbl_count >= 256) r.status = oate_pkg::ST_FULL;
                else if (pos > tbl_count) r.status = oate_pkg::ST_RANGE;
                else begin
                    for (int i = tbl_count; i > pos; i--) tbl[i] = tbl[i-1];
                    tbl[pos] = v;
                    tbl_count++;
                end
            end
            oate_pkg::FN_DEL_IDX: begin
                if (pos >= tbl_count) r.status = oate_pkg::ST_RANGE;
                else begin
                    for (int i = pos; i + 1 < tbl_count; i++) tbl[i] = tbl[i+1];
                    tbl_count--;
                end
            end
            oate_pkg::FN_DEL_VAL, oate_pkg::FN_SEARCH: begin
                hit = find_value(v);
                if (hit < 0) r.status = oate_pkg::ST_MISS;
                else begin
                    r.found = 1'b1;
                    r.match_index = hit[7:0];
                    if (fn == oate_pkg::FN_DEL_VAL) begin
                        for (int i = hit; i + 1 < tbl_count; i++) tbl[i] = tbl[i+1];
                        tbl_count--;
                    end
                end
            end
            oate_pkg::FN_SORT: begin
                for (int i = 1; i < tbl_count; i++) begin
                    key = tbl[i];
                    j = i;
                    while (j > 0 && key < tbl[j-1]) begin
                        tbl[j] = tbl[j-1];
                        j--;
                    end
                    tbl[j] = key;
                end
            end
            default: ;
        endcase
        r.entry_count = tbl_count[8:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        table_reply_t exp_r;
        table_reply_t got;
        int           errs;
        errs = 0;
        if (!aresetn) begin
            tbl_count = 0;
            reply_q.delete();
            err_count <= 0;
            cmd_seen <= 0;
            hit_seen <= 0;
            pending <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                exp_r = apply_command(s_tdata);
                reply_q.push_back(exp_r);
                cmd_seen <= cmd_seen + 1;
                if (exp_r.found) hit_seen <= hit_seen + 1;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[19:0];
                if (reply_q.size() == 0) begin
                    $error("result beat with no command pending: %h", m_tdata);
                    errs++;
                end else begin
                    exp_r = reply_q.pop_front();
                    if (got.status !== exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, got.status);
                        errs++;
                    end
                    if (got.found !== exp_r.found) begin
                        $error("found exp %0d got %0d", exp_r.found, got.found);
                        errs++;
                    end
                    if (got.match_index !== exp_r.match_index) begin
                        $error("match_index exp %0d got %0d",
                               exp_r.match_index, got.match_index);
                        errs++;
                    end
                    if (got.entry_count !== exp_r.entry_count) begin
                        $error("entry_count exp %0d got %0d",
                               exp_r.entry_count, got.entry_count);
                        errs++;
                    end
                end
            end
            if (errs != 0) err_count <= err_count + errs;
            pending <= reply_q.size();
        end
    end
endmodule

// ===== bench/ordered_array_table_engine_core_tb.sv =====
// Testbench top for the ordered array table engine: drives table commands
// under several source idle and sink stall patterns and reports the verdict.
// Depends on oate_pkg, the engine core and ordered_array_table_engine_core_chk.
`timescale 1ns / 100ps
module ordered_array_table_engine_core_tb;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    int          err_count;
    int          pending;
    int          cmd_seen;
    int          hit_seen;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          model_count;
    logic signed [31:0] recent_vals[$];

    always #6 aclk = ~aclk;

    ordered_array_table_engine_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    ordered_array_table_engine_core_chk u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .err_count(err_count), .pending(pending),
        .cmd_seen(cmd_seen), .hit_seen(hit_seen)
    );

    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_cmd(logic [2:0] fn, logic [8:0] pos, logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, v, pos, fn};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // track count loosely to steer indexes toward valid range
        if (fn == oate_pkg::FN_INSERT && model_count < 256 && pos <= model_count) begin
            model_count++;
            recent_vals.push_back(v);
            if (recent_vals.size() > 16) void'(recent_vals.pop_front());
        end
        if (fn == oate_pkg::FN_DEL_IDX && pos < model_count) model_count--;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $signed($urandom_range(15)) - 8;
        endcase
    endfunction

    task automatic random_cmd();
        int sel;
        logic [31:0] v;
        logic [8:0] pos;
        sel = $urandom_range(99);
        v = pick_value();
        if (sel < 12 && recent_vals.size() > 0)
            v = recent_vals[$urandom_range(recent_vals.size() - 1)];
        pos = (model_count > 0 && $urandom_range(9) != 0)
              ? 9'($urandom_range(model_count)) : 9'($urandom);
        if (sel < 40) send_cmd(oate_pkg::FN_INSERT, pos, v);
        else if (sel < 55) send_cmd(oate_pkg::FN_DEL_IDX, pos, v);
        else if (sel < 70) send_cmd(oate_pkg::FN_DEL_VAL, pos, v);
        else if (sel < 92) send_cmd(oate_pkg::FN_SEARCH, pos, v);
        else if (sel < 95) send_cmd(oate_pkg::FN_SORT, pos, v);
        else send_cmd(3'($urandom_range(7, 5)), pos, v);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        model_count = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_cmd(oate_pkg::FN_DEL_IDX, 9'd0, 32'd0);
        send_cmd(oate_pkg::FN_SEARCH, 9'd0, 32'd5);
        send_cmd(oate_pkg::FN_SORT, 9'd0, 32'd0);
        send_cmd(oate_pkg::FN_INSERT, 9'd1, 32'd1);
        send_cmd(oate_pkg::FN_INSERT, 9'd0, 32'h7FFF_FFFF);
        send_cmd(oate_pkg::FN_INSERT, 9'd0, 32'h8000_0000);
        send_cmd(oate_pkg::FN_INSERT, 9'd2, 32'hFFFF_FFFF);
        send_cmd(oate_pkg::FN_INSERT, 9'd1, 32'h5555_5555);
        send_cmd(oate_pkg::FN_INSERT, 9'd5, 32'hAAAA_AAAA);
        send_cmd(oate_pkg::FN_INSERT, 9'd9, 32'd3);
        send_cmd(oate_pkg::FN_INSERT, 9'h1FF, 32'd3);
        send_cmd(oate_pkg::FN_SEARCH, 9'd0, 32'hFFFF_FFFF);
        send_cmd(oate_pkg::FN_SORT, 9'd0, 32'd0);
        send_cmd(oate_pkg::FN_SEARCH, 9'd0, 32'hAAAA_AAAA);
        send_cmd(oate_pkg::FN_DEL_VAL, 9'd0, 32'd12345);
        send_cmd(oate_pkg::FN_DEL_VAL, 9'd0, 32'h7FFF_FFFF);
        model_count--;
        send_cmd(oate_pkg::FN_DEL_IDX, 9'd4, 32'd0);
        send_cmd(oate_pkg::FN_DEL_IDX, 9'd0, 32'd0);
        send_cmd(oate_pkg::FN_DEL_IDX, 9'h100, 32'd0);
        send_cmd(3'd5, 9'd0, 32'd0);
        send_cmd(3'd7, 9'h1FF, 32'hFFFF_FFFF);
        // fill to full, check full flag before range, then search far end
        while (model_count < 256)
            send_cmd(oate_pkg::FN_INSERT, 9'(model_count), $urandom);
        send_cmd(oate_pkg::FN_INSERT, 9'h1FF, 32'd0);
        send_cmd(oate_pkg::FN_INSERT, 9'd0, 32'd0);
        send_cmd(oate_pkg::FN_SEARCH, 9'd0, recent_vals[$]);
        send_cmd(oate_pkg::FN_DEL_IDX, 9'd255, 32'd0);
        send_cmd(oate_pkg::FN_SORT, 9'd0, 32'd0);
        while (model_count > 0) send_cmd(oate_pkg::FN_DEL_IDX, 9'd0, 32'd0);
        recent_vals.delete();
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 12 : 74) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 12 : 74) : 0;
            for (int n = 0; n < 190; n++) begin
                random_cmd();
                if (model_count > 40 && $urandom_range(3) == 0)
                    send_cmd(oate_pkg::FN_DEL_IDX, 9'($urandom_range(model_count - 1)),
                             32'd0);
            end
            drain();
        end

        drain();
        repeat (50) @(posedge aclk);
        $display("Covered %0d commands (%0d matched) across four idle/stall phases,",
                 cmd_seen, hit_seen);
        $display("including empty, full, out-of-range, miss and sort cases.");
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
